@@ rtl/four_level_page_table_mapper_defines.svh @@
// Assertion macros used by the page table mapper controller.
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ptm_pkg.sv @@
// Shared types and constants of the page table mapper.
package ptm_pkg;

   localparam int unsigned TABLE_PAGES_DEF = 64;

   localparam int unsigned ENTRY_W     = 52;
   localparam int unsigned VA_W        = 48;
   localparam int unsigned COUNT_W     = 20;
   localparam int unsigned PFN_W       = 40;
   localparam int unsigned IDX_W       = 9;
   localparam int unsigned STATUS_W    = 2;

   localparam logic [PFN_W-1:0] BASE_RESET_PFN = 40'h00000_00100;
   localparam logic [IDX_W-1:0] SELF_SLOT      = 9'd511;
   localparam logic [IDX_W-1:0] LAST_SLOT      = 9'd511;

   localparam logic             ACTION_MAP  = 1'b0;
   localparam logic             ACTION_WALK = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_PAGES  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FOREIGN   = 2'd3;

   typedef struct packed {
      logic                load_req;
      logic                rd_issue;
      logic                step_level;
      logic                alloc_zero;
      logic                link_write;
      logic                leaf_write;
      logic                clear_write;
      logic                load_rsp;
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_walk_ok;
   } ptm_cmd_type;

   typedef struct packed {
      logic is_walk;
      logic level_last;
      logic entry_zero;
      logic ptr_bad;
      logic pages_full;
      logic count_zero;
      logic count_last;
      logic sweep_page_end;
      logic sweep_mem_end;
   } ptm_stat_type;

endpackage

@@ rtl/ptm_ctrl.sv @@
// Controller state machine of the page table mapper.
`include "four_level_page_table_mapper_defines.svh"

module ptm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  ptm_pkg::ptm_stat_type stat,
   output ptm_pkg::ptm_cmd_type  cmd
);
   import ptm_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_ZERO  = 3'd5;
   localparam logic [2:0] S_LINK  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                walk_ok_ff, walk_ok_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      walk_ok_in   = walk_ok_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (stat.sweep_mem_end) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_START;
            end
         end
         S_START: begin
            status_in  = ST_OK;
            walk_ok_in = 1'b0;
            if (!stat.is_walk && stat.count_zero) begin
               state_in = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_EVAL;
         end
         S_EVAL: begin
            priority if (stat.level_last) begin
               if (stat.is_walk) begin
                  status_in  = stat.entry_zero ? ST_MISSING : ST_OK;
                  walk_ok_in = !stat.entry_zero;
                  state_in   = S_DONE;
               end else begin
                  cmd.leaf_write = 1'b1;
                  state_in       = stat.count_last ? S_DONE : S_READ;
               end
            end else if (stat.entry_zero) begin
               if (stat.is_walk) begin
                  status_in = ST_MISSING;
                  state_in  = S_DONE;
               end else if (stat.pages_full) begin
                  status_in = ST_NO_PAGES;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_ZERO;
               end
            end else if (stat.ptr_bad) begin
               status_in = ST_FOREIGN;
               state_in  = S_DONE;
            end else begin
               cmd.step_level = 1'b1;
               state_in       = S_READ;
            end
         end
         S_ZERO: begin
            // fresh table: one zero beat per entry, then link it in
            cmd.alloc_zero = 1'b1;
            if (stat.sweep_page_end) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            cmd.link_write = 1'b1;
            state_in       = S_READ;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp    = 1'b1;
               cmd.rsp_status  = status_ff;
               cmd.rsp_walk_ok = walk_ok_ff;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_OK;
         walk_ok_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         walk_ok_ff   <= walk_ok_in;
      end
   end

   `PTM_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == S_START, "accepted beat did not start work")
   `PTM_ASSERT_NOW(a_rsp_slot_free, clock, reset, cmd.load_rsp, !rsp_valid_ff || rsp_tready, "result loaded over a waiting beat")
   `PTM_ASSERT_NOW(a_one_writer, clock, reset, 1'b1, $onehot0({cmd.alloc_zero, cmd.link_write, cmd.leaf_write, cmd.clear_write}), "two store writes in one cycle")
   `PTM_ASSERT_NOW(a_clear_blocks, clock, reset, state_ff == S_CLEAR, !req_tready, "request taken during clearing pass")

endmodule

@@ rtl/ptm_datapath.sv @@
// Datapath of the page table mapper: table store, walk registers, result register.
module ptm_datapath #(
   parameter int unsigned TABLE_PAGES = ptm_pkg::TABLE_PAGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ptm_pkg::ENTRY_W-1:0]    csr_wr_data,
   input  logic                           req_action,
   input  logic [ptm_pkg::VA_W-1:0]       req_virt_addr,
   input  logic [ptm_pkg::ENTRY_W-1:0]    req_phys_addr,
   input  logic [ptm_pkg::COUNT_W-1:0]    req_page_count,
   input  ptm_pkg::ptm_cmd_type           cmd,
   output ptm_pkg::ptm_stat_type          stat,
   output logic [ptm_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ptm_pkg::ENTRY_W-1:0]    rsp_translated_addr
);
   import ptm_pkg::*;

   localparam int unsigned PAGE_W = $clog2(TABLE_PAGES);
   localparam int unsigned NF_W   = $clog2(TABLE_PAGES + 1);
   localparam int unsigned ADDR_W = PAGE_W + IDX_W;
   localparam int unsigned DEPTH  = TABLE_PAGES * (1 << IDX_W);

   logic [ENTRY_W-1:0] mem [DEPTH];

   logic                action_ff;
   logic [VA_W-1:0]     va_ff;
   logic [ENTRY_W-1:0]  pa_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [1:0]          level_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [NF_W-1:0]     next_free_ff;
   logic [ADDR_W-1:0]   sweep_ff;
   logic [PFN_W-1:0]    base_ff;
   logic [ENTRY_W-1:0]  root_self_ff;
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                rd_self_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ENTRY_W-1:0]  rsp_addr_ff;

   logic [IDX_W-1:0]    idx;
   logic                slot_is_self;
   logic [ADDR_W-1:0]   slot_addr;
   logic [ENTRY_W-1:0]  entry;
   logic [PFN_W-1:0]    rel;
   logic [PAGE_W-1:0]   new_page;
   logic [ENTRY_W-1:0]  link_value;
   logic [ENTRY_W-1:0]  leaf_value;
   logic [ENTRY_W-1:0]  translated;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic                self_wr;

   always_comb begin
      unique case (level_ff)
         2'd0:    idx = va_ff[47:39];
         2'd1:    idx = va_ff[38:30];
         2'd2:    idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
   end

   // root slot 511 lives in a register so base rewrites need no store port
   assign slot_is_self = (page_ff == '0) && (idx == SELF_SLOT);
   assign slot_addr    = {page_ff, idx};
   assign entry        = rd_self_ff ? root_self_ff : rd_data_ff;
   assign rel          = entry[ENTRY_W-1:12] - base_ff;
   assign new_page     = next_free_ff[PAGE_W-1:0];
   assign link_value   = {base_ff + PFN_W'(next_free_ff), 12'h003};
   assign leaf_value   = {pa_ff[ENTRY_W-1:2], 2'b11};
   assign translated   = {entry[ENTRY_W-1:2], 2'b00} | {{(ENTRY_W-12){1'b0}}, va_ff[11:0]};

   assign stat.is_walk        = (action_ff == ACTION_WALK);
   assign stat.level_last     = (level_ff == 2'd3);
   assign stat.entry_zero     = (entry == '0);
   assign stat.ptr_bad        = (entry[ENTRY_W-1:12] < base_ff) || (rel >= PFN_W'(TABLE_PAGES));
   assign stat.pages_full     = (next_free_ff >= NF_W'(TABLE_PAGES));
   assign stat.count_zero     = (count_ff == '0);
   assign stat.count_last     = (count_ff == COUNT_W'(1));
   assign stat.sweep_page_end = (sweep_ff[IDX_W-1:0] == LAST_SLOT);
   assign stat.sweep_mem_end  = (sweep_ff == ADDR_W'(DEPTH - 1));

   always_comb begin
      wr_en   = 1'b0;
      self_wr = 1'b0;
      wr_addr = slot_addr;
      wr_data = '0;
      priority if (cmd.clear_write) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
      end else if (cmd.alloc_zero) begin
         wr_en   = 1'b1;
         wr_addr = {new_page, sweep_ff[IDX_W-1:0]};
      end else if (cmd.link_write) begin
         wr_en   = !slot_is_self;
         self_wr = slot_is_self;
         wr_data = link_value;
      end else if (cmd.leaf_write) begin
         wr_en   = !slot_is_self;
         self_wr = slot_is_self;
         wr_data = leaf_value;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[slot_addr];
         rd_self_ff <= slot_is_self;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= NF_W'(1);
         sweep_ff     <= '0;
         base_ff      <= BASE_RESET_PFN;
         root_self_ff <= {BASE_RESET_PFN, 12'h003};
         level_ff     <= '0;
         page_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            base_ff      <= csr_wr_data[ENTRY_W-1:12];
            root_self_ff <= {csr_wr_data[ENTRY_W-1:12], 12'h003};
         end else if (self_wr) begin
            root_self_ff <= wr_data;
         end
         if (cmd.clear_write) begin
            sweep_ff <= stat.sweep_mem_end ? '0 : sweep_ff + ADDR_W'(1);
         end else if (cmd.alloc_zero) begin
            sweep_ff <= stat.sweep_page_end ? '0 : sweep_ff + ADDR_W'(1);
         end
         priority if (cmd.load_req) begin
            level_ff <= '0;
            page_ff  <= '0;
         end else if (cmd.step_level) begin
            level_ff <= level_ff + 2'd1;
            page_ff  <= rel[PAGE_W-1:0];
         end else if (cmd.link_write) begin
            level_ff     <= level_ff + 2'd1;
            page_ff      <= new_page;
            next_free_ff <= next_free_ff + NF_W'(1);
         end else if (cmd.leaf_write) begin
            level_ff <= '0;
            page_ff  <= '0;
         end else begin
            level_ff <= level_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         va_ff     <= req_virt_addr;
         pa_ff     <= req_phys_addr;
         count_ff  <= req_page_count;
      end else if (cmd.leaf_write) begin
         va_ff    <= va_ff + VA_W'(4096);
         pa_ff    <= pa_ff + ENTRY_W'(4096);
         count_ff <= count_ff - COUNT_W'(1);
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_addr_ff   <= cmd.rsp_walk_ok ? translated : '0;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_translated_addr = rsp_addr_ff;

endmodule

@@ rtl/four_level_page_table_mapper.sv @@
// Four-level page table mapper: map and walk over an internal store of table pages.
// After reset the block runs a clearing pass over the whole table store, with req_tready
// low; csr writes of table_base are taken at any time. Every level uses the single store
// port in turn: address, then registered read data and decode. A walk ends early on a
// fault. A map writes one leaf per page and first builds each missing table: zero beats
// over its entries, then a link beat. One request is in flight at a time; a finished
// result sits in the output register while the next request is taken.
module four_level_page_table_mapper #(
   parameter int unsigned TABLE_PAGES = ptm_pkg::TABLE_PAGES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [51:0]   csr_wr_data,   // table_base, bits 11:0 dropped
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [119:0]  req_tdata,     // virt_addr[47:0], phys_addr[99:48], page_count[119:100]
   input  logic          req_tuser,     // action
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata,     // translated_addr[51:0], zero[55:52]
   output logic [1:0]    rsp_tuser      // status
);
   import ptm_pkg::*;

   ptm_cmd_type  cmd;
   ptm_stat_type stat;
   logic [ENTRY_W-1:0] translated;

   ptm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ptm_datapath #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_action          (req_tuser),
      .req_virt_addr       (req_tdata[47:0]),
      .req_phys_addr       (req_tdata[99:48]),
      .req_page_count      (req_tdata[119:100]),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_status          (rsp_tuser),
      .rsp_translated_addr (translated)
   );

   assign rsp_tdata = {4'b0000, translated};

endmodule
